// File: hw/rtl/vwq_pkg.sv
// Shared constants and types for the vehicle warning qualifier.
package vwq_pkg;

	localparam int TICK_COUNT_WIDTH = 10;
	localparam int LIMIT_W = 10;
	localparam int CMP_W = (TICK_COUNT_WIDTH > LIMIT_W) ? TICK_COUNT_WIDTH : LIMIT_W;

	localparam int OIL_W = 8;
	localparam int TEMP_W = 9;
	localparam int BATT_W = 15;
	localparam int FUEL_W = 7;
	localparam int EXT_W = 5;
	localparam int MASK_W = 9;
	localparam int CODE_W = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [TICK_COUNT_WIDTH-1:0] tick_count_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	localparam tick_count_t CNT_MAX = {TICK_COUNT_WIDTH{1'b1}};

	localparam logic [OIL_W-1:0] OIL_LOW_X10 = 8'd10;
	localparam logic signed [TEMP_W-1:0] COOLANT_HIGH_C = 9'sd110;
	localparam logic [BATT_W-1:0] BATT_LOW_SET_MV = 15'd12000;
	localparam logic [BATT_W-1:0] BATT_LOW_CLEAR_MV = 15'd12500;
	localparam logic [BATT_W-1:0] BATT_HIGH_SET_MV = 15'd15000;
	localparam logic [BATT_W-1:0] BATT_HIGH_CLEAR_MV = 15'd14500;
	localparam logic [FUEL_W-1:0] FUEL_LOW_SET = 7'd10;
	localparam logic [FUEL_W-1:0] FUEL_LOW_CLEAR = 7'd13;

	localparam limit_t OIL_LIMIT_RESET = 10'd40;
	localparam limit_t COOLANT_LIMIT_RESET = 10'd60;
	localparam limit_t BATTERY_LIMIT_RESET = 10'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OIL_LIMIT     = 2'd0,
		REG_COOLANT_LIMIT = 2'd1,
		REG_BATTERY_LIMIT = 2'd2
	} cfg_reg_t;

	localparam int MASK_OIL = 0;
	localparam int MASK_BATTERY = 1;
	localparam int MASK_COOLANT = 2;
	localparam int MASK_CHECK = 3;
	localparam int MASK_FUEL = 4;
	localparam int MASK_EXT_LO = 5;

endpackage

// File: hw/rtl/vwq_sample_if.sv
// Channel carrying one tick of sensor samples.
interface vwq_sample_if;
	logic valid;
	logic ready;
	logic engine_running;
	logic [vwq_pkg::OIL_W-1:0] oil_pressure_x10;
	logic signed [vwq_pkg::TEMP_W-1:0] coolant_temp_c;
	logic [vwq_pkg::BATT_W-1:0] battery_mv;
	logic [vwq_pkg::FUEL_W-1:0] fuel_percent;
	logic [vwq_pkg::EXT_W-1:0] other_warnings;

	modport source (output valid, engine_running, oil_pressure_x10, coolant_temp_c,
		battery_mv, fuel_percent, other_warnings, input ready);
	modport sink (input valid, engine_running, oil_pressure_x10, coolant_temp_c,
		battery_mv, fuel_percent, other_warnings, output ready);
endinterface

// File: hw/rtl/vwq_result_if.sv
// Channel carrying one warning result per tick.
interface vwq_result_if;
	logic valid;
	logic ready;
	logic [vwq_pkg::MASK_W-1:0] warn_mask;
	logic [vwq_pkg::CODE_W-1:0] highest_warning;

	modport source (output valid, warn_mask, highest_warning, input ready);
	modport sink (input valid, warn_mask, highest_warning, output ready);
endinterface

// File: hw/rtl/vehicle_warning_qualifier_unit.sv
// Vehicle warning qualifier: one sensor tick in, one warning mask and priority code out.
// Takes one item per clock unless stalled. Each accepted tick updates the qualification
// counters, warning latches and output register together; the input stays ready while
// that register is empty or being drained, so the sustained rate is one item per cycle
// while results are taken. Oil and coolant warnings latch until reset. Limits are to be
// written via the cfg port while no item is in flight; the block does not check this.
module vehicle_warning_qualifier_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	vwq_sample_if.sink                      sample,
	vwq_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [vwq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vwq_pkg::LIMIT_W-1:0]     cfg_data
);

	vwq_pkg::limit_t oil_limit_q, coolant_limit_q, battery_limit_q;

	vwq_pkg::tick_count_t oil_cnt_q, coolant_cnt_q, batt_low_cnt_q, batt_high_cnt_q;
	logic oil_latched_q, coolant_latched_q, batt_low_q, batt_high_q, fuel_low_q;

	vwq_pkg::tick_count_t oil_cnt_d, coolant_cnt_d, batt_low_cnt_d, batt_high_cnt_d;
	logic oil_latched_d, coolant_latched_d, batt_low_d, batt_high_d, fuel_low_d;

	logic [vwq_pkg::MASK_W-1:0] mask_d;
	logic [vwq_pkg::CODE_W-1:0] code_d;

	logic out_valid_q;
	logic [vwq_pkg::MASK_W-1:0] mask_q;
	logic [vwq_pkg::CODE_W-1:0] code_q;

	logic accept;

	function automatic vwq_pkg::tick_count_t sat_inc(input vwq_pkg::tick_count_t c);
		return (c == vwq_pkg::CNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic reached(input vwq_pkg::tick_count_t c, input vwq_pkg::limit_t lim);
		logic [vwq_pkg::CMP_W-1:0] cx, lx;
		cx = vwq_pkg::CMP_W'(c);
		lx = vwq_pkg::CMP_W'(lim);
		return cx >= lx;
	endfunction

	assign sample.ready = !out_valid_q || result.ready;
	assign accept = sample.valid && sample.ready;

	always_comb begin
		logic run;
		logic [vwq_pkg::BATT_W-1:0] batt;
		run  = sample.engine_running;
		batt = sample.battery_mv;

		oil_latched_d = oil_latched_q;
		if (run && (sample.oil_pressure_x10 < vwq_pkg::OIL_LOW_X10)) begin
			oil_cnt_d = sat_inc(oil_cnt_q);
			if (reached(oil_cnt_d, oil_limit_q)) oil_latched_d = 1'b1;
		end else begin
			oil_cnt_d = '0;
		end

		coolant_latched_d = coolant_latched_q;
		if (sample.coolant_temp_c > vwq_pkg::COOLANT_HIGH_C) begin
			coolant_cnt_d = sat_inc(coolant_cnt_q);
			if (reached(coolant_cnt_d, coolant_limit_q)) coolant_latched_d = 1'b1;
		end else begin
			coolant_cnt_d = '0;
		end

		// battery low also drops whenever the engine is off
		batt_low_d = batt_low_q;
		if (!run) begin
			batt_low_cnt_d = '0;
			batt_low_d = 1'b0;
		end else if (batt < vwq_pkg::BATT_LOW_SET_MV) begin
			batt_low_cnt_d = sat_inc(batt_low_cnt_q);
			if (reached(batt_low_cnt_d, battery_limit_q)) batt_low_d = 1'b1;
		end else begin
			batt_low_cnt_d = '0;
			if (batt > vwq_pkg::BATT_LOW_CLEAR_MV) batt_low_d = 1'b0;
		end

		batt_high_d = batt_high_q;
		if (batt > vwq_pkg::BATT_HIGH_SET_MV) begin
			batt_high_cnt_d = sat_inc(batt_high_cnt_q);
			if (reached(batt_high_cnt_d, battery_limit_q)) batt_high_d = 1'b1;
		end else begin
			batt_high_cnt_d = '0;
			if (batt < vwq_pkg::BATT_HIGH_CLEAR_MV) batt_high_d = 1'b0;
		end

		fuel_low_d = fuel_low_q;
		if (sample.fuel_percent < vwq_pkg::FUEL_LOW_SET) fuel_low_d = 1'b1;
		else if (sample.fuel_percent > vwq_pkg::FUEL_LOW_CLEAR) fuel_low_d = 1'b0;

		mask_d = '0;
		mask_d[vwq_pkg::MASK_OIL]     = oil_latched_d;
		mask_d[vwq_pkg::MASK_BATTERY] = batt_low_d || batt_high_d;
		mask_d[vwq_pkg::MASK_COOLANT] = coolant_latched_d;
		mask_d[vwq_pkg::MASK_CHECK]   = sample.other_warnings[0];
		mask_d[vwq_pkg::MASK_FUEL]    = fuel_low_d;
		mask_d[vwq_pkg::MASK_W-1:vwq_pkg::MASK_EXT_LO] =
			sample.other_warnings[vwq_pkg::EXT_W-1:1];

		// scan downward so the lowest set bit wins
		code_d = '0;
		for (int i = vwq_pkg::MASK_W - 1; i >= 0; i--) begin
			if (mask_d[i]) code_d = vwq_pkg::CODE_W'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oil_limit_q     <= vwq_pkg::OIL_LIMIT_RESET;
			coolant_limit_q <= vwq_pkg::COOLANT_LIMIT_RESET;
			battery_limit_q <= vwq_pkg::BATTERY_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vwq_pkg::REG_OIL_LIMIT:     oil_limit_q <= cfg_data;
				vwq_pkg::REG_COOLANT_LIMIT: coolant_limit_q <= cfg_data;
				vwq_pkg::REG_BATTERY_LIMIT: battery_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oil_cnt_q         <= '0;
			coolant_cnt_q     <= '0;
			batt_low_cnt_q    <= '0;
			batt_high_cnt_q   <= '0;
			oil_latched_q     <= 1'b0;
			coolant_latched_q <= 1'b0;
			batt_low_q        <= 1'b0;
			batt_high_q       <= 1'b0;
			fuel_low_q        <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (accept) begin
				oil_cnt_q         <= oil_cnt_d;
				coolant_cnt_q     <= coolant_cnt_d;
				batt_low_cnt_q    <= batt_low_cnt_d;
				batt_high_cnt_q   <= batt_high_cnt_d;
				oil_latched_q     <= oil_latched_d;
				coolant_latched_q <= coolant_latched_d;
				batt_low_q        <= batt_low_d;
				batt_high_q       <= batt_high_d;
				fuel_low_q        <= fuel_low_d;
				out_valid_q       <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken; load a new one on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= mask_d;
			code_q <= code_d;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.warn_mask       = mask_q;
	assign result.highest_warning = code_q;

endmodule
